[rtl/bfa_pkg.sv]
`default_nettype none
package bfa_pkg;
    localparam int DefPoolBytes = 1024;
    localparam int TagBytes = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_DBL_FREE = 2'd2
    } t_status;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;
endpackage
`default_nettype wire

[rtl/bfa_tag_mem.sv]
`default_nettype none
// Byte-wide pool memory with one port and registered read data.
module bfa_tag_mem #(
    parameter int POOL_BYTES = 1024,
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [7:0]    i_wdata,
    output logic      [7:0]    o_rdata
);
    logic [7:0] r_mem [POOL_BYTES];

    // Registered read returns the contents from before a write in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[rtl/best_fit_boundary_tag_allocator_core.sv]
`default_nettype none
// An allocate walks the blocks one tag read at a time, then plans and writes the tags;
// a free reads its own and neighbouring tags, then writes the merged tags.
// The single-byte memory port sets the pace.
// One item is processed at a time; the result waits in an output register and the next
// item is accepted in the cycle after the result is taken.
// After reset a clearing pass writes every pool byte, with the initial tags at both ends.
module best_fit_boundary_tag_allocator_core #(
    parameter int POOL_BYTES = bfa_pkg::DefPoolBytes
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // request_size[9:0], data_offset[19:10]
    input  wire logic        s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata   // block_offset[9:0], status[11:10]
);
    import bfa_pkg::*;

    localparam int AW = $clog2(POOL_BYTES);
    localparam int PW = 36;                     // signed position width, holds any tag
    localparam logic [31:0] InitTag = 32'(POOL_BYTES - 8);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDW, S_ADONE, S_WR, S_FHDR, S_FRIGHT, S_FLEFT,
        S_FPLAN, S_OUT
    } t_state;

    t_state r_state, r_ret;
    logic [AW-1:0] r_clr;
    logic [9:0]    r_size, r_data;
    logic signed [PW-1:0] r_pos, r_best_pos;
    logic signed [33:0] r_best, r_space, r_tag;
    logic          r_found;
    logic [1:0]    r_k;
    logic [2:0]    r_k2;
    logic signed [PW-1:0] r_rdpos;
    // up to four tag writes queued
    logic signed [PW-1:0] r_wpos [4];
    logic [31:0]   r_wval [4];
    logic [2:0]    r_wn, r_wi;
    logic [9:0]    r_out_off;
    t_status       r_out_st;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata, mem_rdata;
    logic signed [PW+1:0] a_pos;
    logic          a_in;

    bfa_tag_mem #(.POOL_BYTES(POOL_BYTES), .AW(AW)) u_mem (
        .i_clk, .i_we(mem_we), .i_addr(mem_addr), .i_wdata(mem_wdata), .o_rdata(mem_rdata)
    );

    // Memory port steering.
    always_comb begin
        a_pos     = '0;
        mem_we    = 1'b0;
        mem_wdata = 8'd0;
        if (r_state == S_CLEAR) begin
            a_pos = (PW+2)'({1'b0, r_clr});
            mem_we = 1'b1;
            if (r_clr < 4) mem_wdata = InitTag[8*r_clr[1:0] +: 8];
            else if (r_clr >= AW'(POOL_BYTES - 4)) mem_wdata = InitTag[8*r_clr[1:0] +: 8];
        end else if (r_state == S_WR) begin
            a_pos = (PW+2)'(r_wpos[r_wi[1:0]]) + (PW+2)'(r_k);
            mem_we = 1'b1;
            mem_wdata = r_wval[r_wi[1:0]][8*r_k +: 8];
        end else begin
            a_pos = (PW+2)'(r_rdpos) + (PW+2)'(r_k);
        end
        a_in = (a_pos >= 0) && (a_pos < POOL_BYTES);
        if (!a_in) mem_we = 1'b0;
        mem_addr = a_pos[AW-1:0];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'd0, r_out_st, r_out_off};

    logic signed [33:0] tag_now, spare;
    logic r_ain;
    assign tag_now = 34'(signed'({mem_rdata & {8{r_ain}}, r_tag[31:8]}));
    assign spare   = r_best - 34'(r_size) - 34'sd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_ain <= a_in;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(POOL_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (s_axis_tvalid) begin
                    r_size  <= s_axis_tdata[9:0];
                    r_data  <= s_axis_tdata[19:10];
                    r_pos   <= '0;
                    r_rdpos <= '0;
                    r_best  <= 34'(POOL_BYTES);
                    r_best_pos <= '0;
                    r_found <= 1'b0;
                    r_k     <= '0;
                    r_wn    <= '0;
                    r_wi    <= '0;
                    if (s_axis_tuser == MODE_FREE) begin
                        r_rdpos <= PW'(s_axis_tdata[19:10]) - PW'(4);
                        r_ret   <= S_FHDR;
                    end else begin
                        r_ret   <= S_ADONE;
                    end
                    r_state <= S_RD;
                    r_k2    <= '0;
                end
                // Issue four byte reads; collect into r_tag.
                S_RD: begin
                    r_k2 <= r_k2 + 1'b1;
                    if (r_k2 != 0) r_tag <= tag_now;
                    if (r_k == 2'd3) r_state <= S_RDW;
                    r_k <= r_k + 1'b1;
                end
                S_RDW: begin
                    r_tag <= tag_now;
                    r_k2  <= '0;
                    r_state <= r_ret;
                end
                S_ADONE: begin
                    if (r_tag >= $signed(34'(r_size)) && r_tag < r_best) begin
                        r_best <= r_tag; r_best_pos <= r_pos; r_found <= 1'b1;
                    end
                    if (r_pos + PW'(8) + PW'(r_tag < 0 ? -r_tag : r_tag) < PW'(POOL_BYTES)
                        && (r_tag < 0 ? -r_tag : r_tag) < 34'(POOL_BYTES)) begin
                        r_pos   <= r_pos + PW'(8) + PW'(r_tag < 0 ? -r_tag : r_tag);
                        r_rdpos <= r_pos + PW'(8) + PW'(r_tag < 0 ? -r_tag : r_tag);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_FPLAN;
                    end
                end
                S_FHDR: begin
                    if (r_tag > 0) begin
                        r_out_off <= '0; r_out_st <= ST_DBL_FREE; r_state <= S_OUT;
                    end else begin
                        r_space <= -r_tag;
                        if (PW'(r_data) + PW'(4) + PW'(-r_tag) < PW'(POOL_BYTES)
                            && -r_tag < 34'(POOL_BYTES)) begin
                            r_rdpos <= PW'(r_data) + PW'(4) + PW'(-r_tag);
                            r_ret <= S_FRIGHT; r_state <= S_RD;
                        end else begin
                            r_tag <= '0; r_state <= S_FRIGHT;
                        end
                    end
                end
                S_FRIGHT: begin
                    if (r_tag > 0) r_space <= r_space + r_tag + 34'sd8;
                    if (r_data > 10'd8) begin
                        r_rdpos <= PW'(r_data) - PW'(8);
                        r_ret <= S_FLEFT; r_state <= S_RD;
                    end else begin
                        r_tag <= '0; r_state <= S_FLEFT;
                    end
                end
                S_FLEFT: begin
                    r_wi <= '0; r_k <= '0; r_wn <= 3'd2;
                    if (r_tag > 0) begin
                        r_wpos[0] <= PW'(r_data) - PW'(12) - PW'(r_tag);
                        r_wpos[1] <= PW'(r_data) - PW'(8) - PW'(r_tag) + PW'(r_space + r_tag + 34'sd8);
                        r_wval[0] <= 32'(r_space + r_tag + 34'sd8);
                        r_wval[1] <= 32'(r_space + r_tag + 34'sd8);
                    end else begin
                        r_wpos[0] <= PW'(r_data) - PW'(4);
                        r_wpos[1] <= PW'(r_data) + PW'(r_space);
                        r_wval[0] <= 32'(r_space);
                        r_wval[1] <= 32'(r_space);
                    end
                    r_out_off <= '0; r_out_st <= ST_OK;
                    r_state <= S_WR;
                end
                // Allocate plan: result and tag writes.
                S_FPLAN: begin
                    r_wi <= '0; r_k <= '0;
                    if (!r_found) begin
                        r_out_off <= '0; r_out_st <= ST_NO_FIT; r_state <= S_OUT;
                    end else begin
                        r_out_off <= 10'(r_best_pos + PW'(4));
                        r_out_st  <= ST_OK;
                        r_state   <= S_WR;
                        r_wpos[0] <= r_best_pos;
                        if (spare <= 0) begin
                            r_wn <= 3'd2;
                            r_wpos[1] <= r_best_pos + PW'(4) + PW'(r_best);
                            r_wval[0] <= 32'(-r_best); r_wval[1] <= 32'(-r_best);
                        end else begin
                            r_wn <= 3'd4;
                            r_wpos[1] <= r_best_pos + PW'(4) + PW'(r_size);
                            r_wpos[2] <= r_best_pos + PW'(8) + PW'(r_size);
                            r_wpos[3] <= r_best_pos + PW'(12) + PW'(r_size) + PW'(spare);
                            r_wval[0] <= 32'(-34'(r_size)); r_wval[1] <= 32'(-34'(r_size));
                            r_wval[2] <= 32'(spare); r_wval[3] <= 32'(spare);
                        end
                    end
                end
                S_WR: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_wi <= r_wi + 1'b1;
                        if (r_wi + 1'b1 == r_wn) r_state <= S_OUT;
                    end
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks.
    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_out_st != 2'd3) else $error("bad status");
    a_noff_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_st != ST_OK) |-> r_out_off == '0) else $error("offset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("drop");
endmodule
`default_nettype wire
